[hw/rtl/ctta_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ctta_pkg
// Shared types and constants of the clock tree tick accumulator.
// ----------------------------------------------------------------------------
package ctta_pkg;

  localparam int unsigned PeriodW = 20;
  localparam int unsigned ElapsedW = 31;
  localparam int unsigned TickW = 32;
  localparam int unsigned AccW = 34;
  localparam int unsigned QueueDepth = 2;

  localparam logic [PeriodW-1:0] DcoPeriodRst = 20'd666;
  localparam logic [PeriodW-1:0] LfxtPeriodRst = 20'd30517;
  localparam logic [PeriodW-1:0] VloPeriodRst = 20'd83333;
  localparam logic [TickW-1:0] TickMax = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    RegMclk = 3'd0,
    RegSmclk = 3'd1,
    RegAclk = 3'd2,
    RegDco = 3'd3,
    RegLfxt = 3'd4,
    RegVlo = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] cycles;
    logic       cpu_off;
    logic       osc_off;
    logic       scg0;
    logic       scg1;
  } in_item_t;

  typedef struct packed {
    logic [ElapsedW-1:0] elapsed_ns;
    logic [TickW-1:0]    lfxt1_ticks;
    logic [TickW-1:0]    vlo_ticks;
    logic [TickW-1:0]    dco_ticks;
    logic [7:0]          mclk_ticks;
    logic [TickW-1:0]    aclk_ticks;
    logic [TickW-1:0]    smclk_ticks;
  } out_item_t;

  typedef struct packed {
    logic [3:0]         mclk_setup;
    logic [2:0]         smclk_setup;
    logic [3:0]         aclk_setup;
    logic [PeriodW-1:0] dco_period;
    logic [PeriodW-1:0] lfxt_period;
    logic [PeriodW-1:0] vlo_period;
  } cfg_t;

  // Classified word handed from the front end to the back end.
  typedef struct packed {
    logic [AccW-1:0] elapsed;
    logic [7:0]      mclk_ticks;
    logic            lfxt_run;
    logic            dco_run;
    logic            scg1;
  } job_t;

endpackage
`default_nettype wire

[hw/rtl/ctta_cfg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ctta_cfg
// APB register file holding the clock setup and oscillator periods.
// ----------------------------------------------------------------------------
module ctta_cfg (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output ctta_pkg::cfg_t   cfg_o
);
  import ctta_pkg::*;

  cfg_t cfg_q;
  logic [2:0] idx;
  logic wr;

  assign idx = paddr[4:2];
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mclk_setup <= '0;
      cfg_q.smclk_setup <= '0;
      cfg_q.aclk_setup <= '0;
      cfg_q.dco_period <= DcoPeriodRst;
      cfg_q.lfxt_period <= LfxtPeriodRst;
      cfg_q.vlo_period <= VloPeriodRst;
    end else if (wr) begin
      case (idx)
        RegMclk:  cfg_q.mclk_setup <= pwdata[3:0];
        RegSmclk: cfg_q.smclk_setup <= pwdata[2:0];
        RegAclk:  cfg_q.aclk_setup <= pwdata[3:0];
        RegDco:   cfg_q.dco_period <= pwdata[PeriodW-1:0];
        RegLfxt:  cfg_q.lfxt_period <= pwdata[PeriodW-1:0];
        RegVlo:   cfg_q.vlo_period <= pwdata[PeriodW-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      RegMclk:  prdata[3:0] = cfg_q.mclk_setup;
      RegSmclk: prdata[2:0] = cfg_q.smclk_setup;
      RegAclk:  prdata[3:0] = cfg_q.aclk_setup;
      RegDco:   prdata[PeriodW-1:0] = cfg_q.dco_period;
      RegLfxt:  prdata[PeriodW-1:0] = cfg_q.lfxt_period;
      RegVlo:   prdata[PeriodW-1:0] = cfg_q.vlo_period;
      default:  prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

[hw/rtl/ctta_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ctta_front
// Accepts input words, computes elapsed time and oscillator gating.
// ----------------------------------------------------------------------------
module ctta_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire ctta_pkg::cfg_t   cfg_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire ctta_pkg::in_item_t in_data_i,
  output logic                  job_valid_o,
  input  wire logic             job_ready_i,
  output ctta_pkg::job_t        job_o
);
  import ctta_pkg::*;

  logic busy_q;
  job_t job_q;
  logic [1:0] selm;
  logic [PeriodW-1:0] lf_period, src_period;
  logic [10:0] scaled;
  logic [AccW-1:0] product;
  job_t job_d;

  assign selm = cfg_i.mclk_setup[3:2];
  assign lf_period = (cfg_i.aclk_setup[3:2] == 2'd2) ? cfg_i.vlo_period : cfg_i.lfxt_period;
  assign src_period = selm[1] ? lf_period : cfg_i.dco_period;
  assign scaled = {3'd0, in_data_i.cycles} << cfg_i.mclk_setup[1:0];
  assign product = {3'd0, ElapsedW'(scaled) * ElapsedW'(src_period)};

  always_comb begin
    job_d.elapsed = product;
    job_d.mclk_ticks = in_data_i.cpu_off ? 8'd0 : in_data_i.cycles;
    job_d.lfxt_run = !in_data_i.osc_off || (selm[1] && !in_data_i.cpu_off);
    job_d.dco_run = !in_data_i.scg0 || (!selm[1] && !in_data_i.cpu_off)
                    || !cfg_i.smclk_setup[2];
    job_d.scg1 = in_data_i.scg1;
  end

  assign in_ready_o = !busy_q;
  assign job_valid_o = busy_q;
  assign job_o = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      busy_q <= 1'b1;
    end else if (job_ready_i) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      job_q <= job_d;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/ctta_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ctta_queue
// Two-entry queue of classified words between front and back ends.
// ----------------------------------------------------------------------------
module ctta_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_valid_i,
  output logic                wr_ready_o,
  input  wire ctta_pkg::job_t wr_data_i,
  output logic                rd_valid_o,
  input  wire logic           rd_ready_i,
  output ctta_pkg::job_t      rd_data_o
);
  import ctta_pkg::*;

  job_t mem_q [QueueDepth];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign wr_ready_o = cnt_q != 2'(QueueDepth);
  assign rd_valid_o = cnt_q != 2'd0;
  assign push = wr_valid_i && wr_ready_o;
  assign pop = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_data_i;
  end

endmodule
`default_nettype wire

[hw/rtl/ctta_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ctta_back
// Advances the three oscillator accumulators with a shared restoring divider
// and forms the divided auxiliary and sub-main ticks.
// ----------------------------------------------------------------------------
module ctta_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire ctta_pkg::cfg_t  cfg_i,
  input  wire logic            job_valid_i,
  output logic                 job_ready_o,
  input  wire ctta_pkg::job_t  job_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output ctta_pkg::out_item_t  out_data_o
);
  import ctta_pkg::*;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StDiv  = 4'b0010,
    StFin  = 4'b0100,
    StOut  = 4'b1000
  } state_e;

  state_e state_q;
  logic [1:0] osc_q;       // 0 lfxt1, 1 vlo, 2 dco
  logic [5:0] bit_q;
  job_t job_q;
  logic [AccW:0] quo_q;
  logic [PeriodW:0] rem_q;
  logic [PeriodW-1:0] lfxt_rem_q, vlo_rem_q, dco_rem_q;
  logic [TickW-1:0] lfxt_t_q, vlo_t_q;
  logic [2:0] arem_q, srem_q;
  out_item_t out_q;

  logic [PeriodW-1:0] period;
  logic run;
  logic [PeriodW+1:0] trial;
  logic [TickW-1:0] sat_q;
  logic [TickW-1:0] dco_now;
  logic [TickW-1:0] lf_t, s_src;
  logic [TickW:0] a_acc, s_acc;
  logic [TickW-1:0] a_out, s_out;
  logic [1:0] diva, divs;

  always_comb begin
    unique case (osc_q)
      2'd0: begin
        period = cfg_i.lfxt_period; run = job_q.lfxt_run;
      end
      2'd1: begin
        period = cfg_i.vlo_period; run = 1'b1;
      end
      default: begin
        period = cfg_i.dco_period; run = job_q.dco_run;
      end
    endcase
  end

  assign trial = {rem_q, quo_q[AccW]} - {2'b0, period};
  assign sat_q = (quo_q[AccW:TickW] != '0) ? TickMax : quo_q[TickW-1:0];

  // DCO ticks of the current word, valid while finishing the last oscillator.
  assign dco_now = (period != '0 && run) ? sat_q : '0;

  assign diva = cfg_i.aclk_setup[1:0];
  assign divs = cfg_i.smclk_setup[1:0];
  assign lf_t = (cfg_i.aclk_setup[3:2] == 2'd2) ? vlo_t_q : lfxt_t_q;
  assign s_src = cfg_i.smclk_setup[2] ? lf_t : dco_now;
  assign a_acc = {30'd0, arem_q} + {1'b0, lf_t};
  assign s_acc = {30'd0, srem_q} + {1'b0, s_src};
  assign a_out = ((a_acc >> diva) > {1'b0, TickMax}) ? TickMax : TickW'(a_acc >> diva);
  assign s_out = ((s_acc >> divs) > {1'b0, TickMax}) ? TickMax : TickW'(s_acc >> divs);

  assign job_ready_o = state_q == StIdle;
  assign out_valid_o = state_q == StOut;
  assign out_data_o = out_q;

  // One quotient bit per cycle; 35 quotient bits per oscillator.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      osc_q <= 2'd0;
      bit_q <= '0;
      lfxt_rem_q <= '0;
      vlo_rem_q <= '0;
      dco_rem_q <= '0;
      arem_q <= '0;
      srem_q <= '0;
    end else begin
      unique case (state_q)
        StIdle: if (job_valid_i) begin
          state_q <= StFin;
          osc_q <= 2'd3;
        end
        StDiv: begin
          if (bit_q == 6'(AccW)) state_q <= StFin;
          bit_q <= bit_q + 6'd1;
        end
        StFin: begin
          if (osc_q != 2'd3) begin
            if (period != '0 && run) begin
              unique case (osc_q)
                2'd0: lfxt_rem_q <= rem_q[PeriodW-1:0];
                2'd1: vlo_rem_q <= rem_q[PeriodW-1:0];
                default: dco_rem_q <= rem_q[PeriodW-1:0];
              endcase
            end
          end
          if (osc_q == 2'd2) begin
            state_q <= StOut;
            arem_q <= a_acc[2:0] & ((3'd1 << diva) - 3'd1);
            if (!job_q.scg1) srem_q <= s_acc[2:0] & ((3'd1 << divs) - 3'd1);
          end else begin
            osc_q <= osc_q + 2'd1;
            state_q <= StDiv;
            bit_q <= '0;
          end
        end
        StOut: if (out_ready_i) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && job_valid_i) job_q <= job_i;
    if (state_q == StFin && osc_q != 2'd2) begin
      rem_q <= '0;
      quo_q <= (osc_q == 2'd3) ? {1'b0, job_q.elapsed} + {15'd0, lfxt_rem_q}
             : (osc_q == 2'd0) ? {1'b0, job_q.elapsed} + {15'd0, vlo_rem_q}
             : {1'b0, job_q.elapsed} + {15'd0, dco_rem_q};
    end
    if (state_q == StDiv) begin
      if (!trial[PeriodW+1]) begin
        rem_q <= trial[PeriodW:0];
        quo_q <= {quo_q[AccW-1:0], 1'b1};
      end else begin
        rem_q <= {rem_q[PeriodW-1:0], quo_q[AccW]};
        quo_q <= {quo_q[AccW-1:0], 1'b0};
      end
    end
    if (state_q == StFin && osc_q == 2'd0) lfxt_t_q <= (period != '0 && run) ? sat_q : '0;
    if (state_q == StFin && osc_q == 2'd1) vlo_t_q <= (period != '0) ? sat_q : '0;
    if (state_q == StFin && osc_q == 2'd2) begin
      out_q.elapsed_ns <= job_q.elapsed[ElapsedW-1:0];
      out_q.lfxt1_ticks <= lfxt_t_q;
      out_q.vlo_ticks <= vlo_t_q;
      out_q.dco_ticks <= dco_now;
      out_q.mclk_ticks <= job_q.mclk_ticks;
      out_q.aclk_ticks <= a_out;
      out_q.smclk_ticks <= job_q.scg1 ? '0 : s_out;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDiv |-> bit_q <= 6'(AccW)) else $error("divider overran");

endmodule
`default_nettype wire

[hw/rtl/clock_tree_tick_accumulator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// clock_tree_tick_accumulator
// Converts main-clock cycle counts to elapsed time and oscillator ticks.
// ----------------------------------------------------------------------------
// The back end runs a shared restoring divider, one quotient bit per cycle over
// 35 bits, once for each of the three oscillators. A two-entry queue lets the
// front end take further words while the back end divides. Registers are
// written over APB.
module clock_tree_tick_accumulator (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [4:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire ctta_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output ctta_pkg::out_item_t      out_data_o
);
  import ctta_pkg::*;

  cfg_t cfg;
  job_t f_job, q_job;
  logic f_valid, f_ready, q_valid, q_ready;

  assign pready = 1'b1;

  ctta_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .cfg_o(cfg)
  );

  ctta_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg), .in_valid_i, .in_ready_o,
    .in_data_i, .job_valid_o(f_valid), .job_ready_i(f_ready), .job_o(f_job)
  );

  ctta_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_job),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_data_o(q_job)
  );

  ctta_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg), .job_valid_i(q_valid), .job_ready_o(q_ready),
    .job_i(q_job), .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule
`default_nettype wire
